// File: hdl/lrs_pkg.sv
// Package for the latching relay sequencer: request and result types, phase codes, register indexes.
`default_nettype none
package lrs_pkg;

    localparam int CHANNELS = 4;

    localparam int TIMER_W = 24;
    localparam int PULSE_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_AUTO_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_DELAY_TICKS = 2'd2;

    localparam logic [2:0] PH_OFF = 3'd0;
    localparam logic [2:0] PH_ON_PULSE = 3'd1;
    localparam logic [2:0] PH_ON = 3'd2;
    localparam logic [2:0] PH_DELAY_OFF = 3'd3;
    localparam logic [2:0] PH_OFF_PULSE = 3'd4;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SWITCH = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [CHANNELS-1:0] channels_on;
        logic                switch_value;
    } lrs_in_t;

    typedef struct packed {
        logic       set_coil;
        logic       reset_coil;
        logic       triac_enable;
        logic [2:0] relay_state;
    } lrs_out_t;

endpackage
`default_nettype wire

// File: hdl/latching_relay_sequencer.sv
// Latching relay sequencer: bistable relay coil pulses, triac enable and off-delay timer.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    lrs_in_t  (cmd, channels_on, switch_value)
//  m_        out        m_valid/m_ready    lrs_out_t (coils, triac, relay_state)
//  cfg_      in         cfg_we (no wait)   cfg_index, cfg_wdata
//
// One request per cycle unless a held result stalls s_: every request yields one
// result in the cycle after it is accepted, the state update and timer decrement
// feeding the result register. s_ready is high while the result register is empty
// or being taken, so a stalled m_ready holds at most one result and back-pressures s_.
// aresetn is synchronous, active low: registers return to their defaults, phase off,
// timer stopped, coils and triac released, no result pending.
`default_nettype none
module latching_relay_sequencer
    import lrs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire lrs_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output lrs_out_t                   m_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    // configuration registers
    logic               auto_mode_reg;
    logic [PULSE_W-1:0] pulse_ticks_reg;
    logic [TIMER_W-1:0] off_delay_ticks_reg;

    // sequencer state
    logic [2:0]         phase_reg, phase_next;
    logic [TIMER_W-1:0] timer_count_reg, timer_count_next;
    logic               timer_running_reg, timer_running_next;
    logic               set_coil_reg, set_coil_next;
    logic               reset_coil_reg, reset_coil_next;
    logic               triac_reg, triac_next;

    // result register
    logic               m_valid_reg;
    lrs_out_t           m_data_reg;

    logic               s_take;
    logic               active;
    logic [TIMER_W-1:0] pulse_load;

    assign s_ready    = !m_valid_reg || m_ready;
    assign s_take     = s_valid && s_ready;
    assign active     = |s_data.channels_on;
    assign pulse_load = {{(TIMER_W-PULSE_W){1'b0}}, pulse_ticks_reg};
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auto_mode_reg       <= 1'b1;
            pulse_ticks_reg     <= PULSE_W'(100);
            off_delay_ticks_reg <= TIMER_W'(1000);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_AUTO_MODE:       auto_mode_reg       <= cfg_wdata[0];
                REG_PULSE_TICKS:     pulse_ticks_reg     <= cfg_wdata[PULSE_W-1:0];
                REG_OFF_DELAY_TICKS: off_delay_ticks_reg <= cfg_wdata[TIMER_W-1:0];
                default: ;  // index beyond the register list: ignored
            endcase
        end
    end

    // Next state for the request on s_data. Expiry is tested after the decrement,
    // and acting on an expired timer stops or reloads it.
    always_comb begin
        logic               expired;
        logic [TIMER_W-1:0] cnt;
        phase_next         = phase_reg;
        cnt                = timer_count_reg;
        timer_running_next = timer_running_reg;
        set_coil_next      = set_coil_reg;
        reset_coil_next    = reset_coil_reg;
        triac_next         = triac_reg;

        if (s_data.cmd == CMD_TICK && timer_running_reg && timer_count_reg != '0) begin
            cnt = timer_count_reg - TIMER_W'(1);
        end
        expired = timer_running_reg && (cnt == '0);
        timer_count_next = cnt;

        if (s_data.cmd == CMD_SWITCH) begin
            if (s_data.switch_value) begin
                set_coil_next = 1'b1; reset_coil_next = 1'b0; triac_next = 1'b1;
                phase_next = PH_ON_PULSE;
            end else begin
                set_coil_next = 1'b0; reset_coil_next = 1'b1; triac_next = 1'b0;
                phase_next = PH_OFF_PULSE;
            end
            timer_count_next   = pulse_load;
            timer_running_next = 1'b1;
        end else begin
            unique case (phase_reg)
                PH_ON_PULSE: begin
                    if (expired) begin
                        timer_running_next = 1'b0;
                        set_coil_next      = 1'b0;
                        phase_next         = PH_ON;
                    end
                end
                PH_OFF_PULSE: begin
                    if (auto_mode_reg && active) begin
                        set_coil_next = 1'b1; reset_coil_next = 1'b0; triac_next = 1'b1;
                        phase_next         = PH_ON_PULSE;
                        timer_count_next   = pulse_load;
                        timer_running_next = 1'b1;
                    end else if (expired) begin
                        timer_running_next = 1'b0;
                        reset_coil_next    = 1'b0;
                        phase_next         = PH_OFF;
                    end
                end
                PH_DELAY_OFF: begin
                    if (auto_mode_reg) begin
                        if (active) begin
                            // channel back on: cancel the off-delay
                            timer_running_next = 1'b0;
                            phase_next         = PH_ON;
                        end else if (expired) begin
                            set_coil_next = 1'b0; reset_coil_next = 1'b1; triac_next = 1'b0;
                            phase_next         = PH_OFF_PULSE;
                            timer_count_next   = pulse_load;
                            timer_running_next = 1'b1;
                        end
                    end
                end
                PH_ON: begin
                    if (auto_mode_reg && !active) begin
                        timer_count_next   = off_delay_ticks_reg;
                        timer_running_next = 1'b1;
                        phase_next         = PH_DELAY_OFF;
                    end
                end
                default: begin
                    // off, and any stray code, behaves as off
                    if (auto_mode_reg) begin
                        phase_next = PH_OFF;
                        if (active) begin
                            set_coil_next = 1'b1; reset_coil_next = 1'b0; triac_next = 1'b1;
                            phase_next         = PH_ON_PULSE;
                            timer_count_next   = pulse_load;
                            timer_running_next = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_OFF;
            timer_count_reg   <= '0;
            timer_running_reg <= 1'b0;
            set_coil_reg      <= 1'b0;
            reset_coil_reg    <= 1'b0;
            triac_reg         <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (s_take) begin
                phase_reg         <= phase_next;
                timer_count_reg   <= timer_count_next;
                timer_running_reg <= timer_running_next;
                set_coil_reg      <= set_coil_next;
                reset_coil_reg    <= reset_coil_next;
                triac_reg         <= triac_next;
                m_valid_reg       <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: no reset needed
    always_ff @(posedge aclk) begin
        if (s_take) begin
            m_data_reg.set_coil     <= set_coil_next;
            m_data_reg.reset_coil   <= reset_coil_next;
            m_data_reg.triac_enable <= triac_next;
            m_data_reg.relay_state  <= phase_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/lrs_checker.sv
// Port-level checker for the latching relay sequencer, bound to the top level.
`default_nettype none
module lrs_checker
    import lrs_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire lrs_out_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_coils: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.set_coil && m_data.reset_coil))
        else $error("both coils driven");

    a_on_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.relay_state == PH_ON_PULSE
            |-> m_data.set_coil && m_data.triac_enable)
        else $error("on pulse without set coil and triac");

    a_off_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.relay_state == PH_OFF_PULSE
            |-> m_data.reset_coil && !m_data.triac_enable)
        else $error("off pulse without reset coil or with triac");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("request refused with empty result register");

endmodule

bind latching_relay_sequencer lrs_checker u_lrs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

// File: tb/sv/latching_relay_sequencer_tb.sv
// Testbench for the latching relay sequencer: directed and random requests against a predictor.
`timescale 1ns / 1ps
module latching_relay_sequencer_tb;
    import lrs_pkg::*;

    // Index past the end of the register list; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Receiver behaviour, re-chosen at random by the receiver process.
    typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_CHOKED} rx_style_t;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the relay phase machine, coil levels and timer,
    // plus its own copy of the three registers. Every accepted request
    // produces exactly one expected result, queued in order.
    // ------------------------------------------------------------------
    class relay_scoreboard;
        logic             auto_on;
        logic [15:0]      pulse_len;
        logic [23:0]      delay_len;
        logic [2:0]       ph;
        logic [23:0]      count;
        logic             running;
        logic             set_l;
        logic             rst_l;
        logic             triac_l;
        lrs_out_t         expected_q[$];
        int               failures;

        function new();
            auto_on   = 1'b1;
            pulse_len = 16'd100;
            delay_len = 24'd1000;
            ph        = PH_OFF;
            count     = '0;
            running   = 1'b0;
            set_l     = 1'b0;
            rst_l     = 1'b0;
            triac_l   = 1'b0;
            failures  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_AUTO_MODE:       auto_on = d[0];
                REG_PULSE_TICKS:     pulse_len = d[PULSE_W-1:0];
                REG_OFF_DELAY_TICKS: delay_len = d[TIMER_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Expired means running with a zero count; looking at it stops the timer.
        function bit timer_done();
            if (running && count == '0) begin
                running = 1'b0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Starting a pulse always drops the opposite coil.
        function void start_on_pulse();
            set_l   = 1'b1;
            rst_l   = 1'b0;
            triac_l = 1'b1;
            ph      = PH_ON_PULSE;
            count   = {8'd0, pulse_len};
            running = 1'b1;
        endfunction

        function void start_off_pulse();
            rst_l   = 1'b1;
            set_l   = 1'b0;
            triac_l = 1'b0;
            ph      = PH_OFF_PULSE;
            count   = {8'd0, pulse_len};
            running = 1'b1;
        endfunction

        function void advance_tick(bit active);
            if (running && count != '0)
                count = count - 1'b1;
            case (ph)
                PH_ON_PULSE: begin
                    if (timer_done()) begin
                        set_l = 1'b0;
                        ph    = PH_ON;
                    end
                end
                PH_OFF_PULSE: begin
                    if (auto_on && active) begin
                        start_on_pulse();
                    end else if (timer_done()) begin
                        rst_l = 1'b0;
                        ph    = PH_OFF;
                    end
                end
                default: begin
                    // manual mode: on, off and delayed-off simply hold
                    if (auto_on) begin
                        case (ph)
                            PH_DELAY_OFF: begin
                                if (active) begin
                                    running = 1'b0;
                                    ph      = PH_ON;
                                end else if (timer_done()) begin
                                    start_off_pulse();
                                end
                            end
                            PH_ON: begin
                                if (!active) begin
                                    count   = delay_len;
                                    running = 1'b1;
                                    ph      = PH_DELAY_OFF;
                                end
                            end
                            default: begin
                                ph = PH_OFF;
                                if (active)
                                    start_on_pulse();
                            end
                        endcase
                    end
                end
            endcase
        endfunction

        function void note_request(lrs_in_t r);
            lrs_out_t e;
            if (r.cmd == CMD_SWITCH) begin
                if (r.switch_value)
                    start_on_pulse();
                else
                    start_off_pulse();
            end else begin
                advance_tick(r.channels_on != '0);
            end
            e.set_coil     = set_l;
            e.reset_coil   = rst_l;
            e.triac_enable = triac_l;
            e.relay_state  = ph;
            expected_q.push_back(e);
        endfunction

        function void check_result(lrs_out_t got);
            lrs_out_t e;
            if (expected_q.size() == 0) begin
                $error("unexpected result %b with nothing outstanding", got);
                failures++;
                return;
            end
            e = expected_q.pop_front();
            if (got.set_coil !== e.set_coil) begin
                $error("set_coil: expected %0d, actual %0d", e.set_coil, got.set_coil);
                failures++;
            end
            if (got.reset_coil !== e.reset_coil) begin
                $error("reset_coil: expected %0d, actual %0d", e.reset_coil, got.reset_coil);
                failures++;
            end
            if (got.triac_enable !== e.triac_enable) begin
                $error("triac_enable: expected %0d, actual %0d",
                       e.triac_enable, got.triac_enable);
                failures++;
            end
            if (got.relay_state !== e.relay_state) begin
                $error("relay_state: expected %0d, actual %0d",
                       e.relay_state, got.relay_state);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals; those the bench drives are at known values from time zero
    // ------------------------------------------------------------------
    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    lrs_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    lrs_out_t              m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    relay_scoreboard sb;

    // random tick runs: a stretch of all-idle or of some-active channels
    int        run_left = 0;
    bit        run_busy = 1'b0;
    int        rx_cycle = 0;
    rx_style_t rx_style = RX_FREE;

    latching_relay_sequencer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5000000;
        $display("latching_relay_sequencer_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Monitor: values read here are the pre-edge ones, as the DUT sees them.
    // The request is noted before the result is checked; a result never
    // leaves on the edge that accepts its own request.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_wdata);
            if (s_valid && s_ready)
                sb.note_request(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    // Receiver: free-running, random, periodic or heavily choked back-pressure.
    always @(posedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 256 == 0)
            rx_style = rx_style_t'($urandom_range(0, 3));
        case (rx_style)
            RX_FREE:     m_ready <= 1'b1;
            RX_RANDOM:   m_ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_ready <= ((rx_cycle % 8) < 5);
            default:     m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Drivers. Each is entered just after a rising edge.
    // ------------------------------------------------------------------
    task automatic send_request(input lrs_in_t r);
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic idle_for(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Drain every outstanding result, then let the pipeline empty.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(posedge aclk);
    endtask

    // Writes all three registers, junk in the unused upper bits, plus a stray
    // write to the unused index; write enable is lowered once at the end.
    task automatic apply_settings(input logic a, input logic [15:0] pl, input logic [23:0] dl);
        cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_write(REG_AUTO_MODE, {23'($urandom), a});
        cfg_write(REG_PULSE_TICKS, {8'($urandom), pl});
        cfg_write(REG_OFF_DELAY_TICKS, dl);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic lrs_in_t tick_req(input logic [CHANNELS-1:0] ch);
        lrs_in_t r;
        r.cmd          = CMD_TICK;
        r.channels_on  = ch;
        r.switch_value = 1'b0;
        return r;
    endfunction

    function automatic lrs_in_t switch_req(input logic v);
        lrs_in_t r;
        r.cmd          = CMD_SWITCH;
        r.channels_on  = '1;
        r.switch_value = v;
        return r;
    endfunction

    // Mostly runs of idle or active ticks so the off-delay and pulses can
    // play out; a tenth switch commands, a twentieth unstructured ticks.
    function automatic lrs_in_t random_request();
        lrs_in_t r;
        int      pick;
        pick           = $urandom_range(0, 99);
        r.switch_value = 1'($urandom_range(0, 1));
        r.channels_on  = 4'($urandom_range(0, 15));
        if (pick < 10) begin
            r.cmd = CMD_SWITCH;
            return r;
        end
        r.cmd = CMD_TICK;
        if (pick < 15)
            return r;
        if (run_left == 0) begin
            run_left = $urandom_range(1, 24);
            run_busy = 1'($urandom_range(0, 1));
        end
        run_left--;
        r.channels_on = run_busy ? 4'($urandom_range(1, 15)) : '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int burst_left;
        int gap;
        sb = new();
        burst_left = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: idle tick holds off, activity starts an on-pulse,
        // switching off mid-pulse clears the set coil, switching on clears reset.
        send_request(tick_req(4'b0000));
        send_request(tick_req(4'b1111));
        send_request(switch_req(1'b0));
        send_request(switch_req(1'b1));
        settle();

        // Short pulses and delay: walk every phase, including a channel
        // coming back during the off-delay and during the off-pulse.
        apply_settings(1'b1, 16'd2, 24'd2);
        send_request(switch_req(1'b0));
        send_request(tick_req(4'b0000));
        send_request(tick_req(4'b0000));
        send_request(tick_req(4'b0001));
        send_request(tick_req(4'b0000));
        send_request(tick_req(4'b0000));
        send_request(tick_req(4'b0000));
        send_request(tick_req(4'b1000));
        send_request(tick_req(4'b0000));
        send_request(tick_req(4'b0000));
        send_request(tick_req(4'b0000));
        send_request(tick_req(4'b0000));
        send_request(tick_req(4'b0100));
        settle();

        // Manual mode with the phase kept across the mode change:
        // ticks only finish pulses, on and off hold whatever the channels do.
        apply_settings(1'b0, 16'd1, 24'd1);
        send_request(tick_req(4'b0000));
        send_request(switch_req(1'b0));
        send_request(tick_req(4'b1111));
        send_request(tick_req(4'b0010));
        send_request(switch_req(1'b1));
        send_request(tick_req(4'b0000));
        send_request(tick_req(4'b0000));
        settle();

        // Random phases over several settings, extremes included.
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: apply_settings(1'b1, 16'd1, 24'd0);
                1: apply_settings(1'b1, 16'd3, 24'd6);
                2: apply_settings(1'b0, 16'd2, 24'd3);
                3: apply_settings(1'b1, 16'hFFFF, 24'hFFFFFF);
                4: apply_settings(1'b1, 16'($urandom_range(1, 8)),
                                  24'($urandom_range(0, 12)));
                5: apply_settings(1'b0, 16'($urandom_range(1, 8)),
                                  24'($urandom_range(0, 12)));
                6: apply_settings(1'b1, 16'd1, 24'd1);
                default: apply_settings(1'($urandom_range(0, 1)),
                                        16'($urandom_range(1, 8)),
                                        24'($urandom_range(0, 12)));
            endcase
            for (int n = 0; n < 200; n++) begin
                // bursts of requests; a quarter of bursts follow on with no gap
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    if (gap != 0)
                        idle_for(gap);
                end
                burst_left--;
                send_request(random_request());
            end
            settle();
        end

        if (sb.failures == 0 && sb.pending() == 0)
            $display("latching_relay_sequencer_tb passed");
        else
            $display("latching_relay_sequencer_tb failed");
        $finish;
    end

endmodule
